FILE: design/swtm_pkg.sv
// Shared constants, types and helpers of the sliding-window throughput meter.
package swtm_pkg;

    localparam int WINDOW      = 10;
    localparam int SLOT_W      = $clog2(WINDOW);
    localparam int COUNT_W     = $clog2(WINDOW + 1);
    localparam int TIME_W      = 32;
    localparam int BYTES_W     = 48;
    localparam int SUM_W       = BYTES_W + 2;
    localparam int GAP_W       = 16;
    localparam int RATE_W      = 32;
    localparam int HELD_W      = 4;
    localparam int KIND_W      = 3;
    localparam int PROD_W      = BYTES_W + 10;
    localparam int DIV_CNT_W   = $clog2(PROD_W + 1);
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 16;

    localparam logic [GAP_W-1:0] MIN_GAP_RESET    = 16'd1000;
    localparam logic [GAP_W-1:0] WRAP_GUESS_RESET = 16'd10000;

    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD      = 3'd0,
        KIND_QUERY    = 3'd1,
        KIND_ROLLBACK = 3'd2,
        KIND_SUSPEND  = 3'd3,
        KIND_RESUME   = 3'd4
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MIN_GAP    = 1'b0,
        REG_WRAP_GUESS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [TIME_W-1:0]  stamp;
        logic [BYTES_W-1:0] total;
    } sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APPLY,
        ST_CHECK,
        ST_RES_RD,
        ST_RES_WR,
        ST_RATE_RD,
        ST_RATE_CALC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    // Fold a slot sum below 2*WINDOW back into the ring.
    function automatic slot_t wrap_slot(input logic [SLOT_W:0] s);
        logic [SLOT_W:0] r;
        r = s;
        if (s >= (SLOT_W + 1)'(WINDOW))
        begin
            r = s - (SLOT_W + 1)'(WINDOW);
        end
        return r[SLOT_W-1:0];
    endfunction

endpackage

FILE: design/swtm_in_if.sv
// Input channel: one command word per handshake.
interface swtm_in_if
    import swtm_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [KIND_W-1:0]         kind;
    logic [TIME_W-1:0]         now_ms;
    logic signed [BYTES_W-1:0] byte_count;

    modport source (output valid, kind, now_ms, byte_count, input ready);
    modport sink   (input valid, kind, now_ms, byte_count, output ready);
endinterface

FILE: design/swtm_out_if.sv
// Output channel: one rate report word per handshake.
interface swtm_out_if
    import swtm_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RATE_W-1:0]  rate;
    logic [BYTES_W-1:0] total_bytes;
    logic [HELD_W-1:0]  samples_held;
    logic               is_suspended;

    modport source (output valid, rate, total_bytes, samples_held, is_suspended, input ready);
    modport sink   (input valid, rate, total_bytes, samples_held, is_suspended, output ready);
endinterface

FILE: design/sliding_window_throughput_meter.sv
// Sliding-window throughput meter: byte total, sample ring in RAM, rate report.
//
// Each command word (add, query, rollback, suspend, resume) yields one report word with
// the rate in bytes per second measured from the oldest held sample, the running byte
// total, the number of held samples and the suspend flag. Samples (timestamp and total)
// live in a small RAM ring read and written one entry per cycle. One word is processed
// at a time. With samples held and a nonzero span the rate comes from the bit-serial
// 58-step divider that forms bytes*1000/span; an add of a nonnegative count also checks
// the newest sample first. An empty window or a zero span skips the divider. A resume
// while suspended with samples held adds a timestamp read-modify-write sweep over them,
// and a stalled output holds the finished word in the done state until the output frees.
// A new word is taken while the previous report still waits on the output.
// Configuration writes are taken at any time and should land while idle.
module sliding_window_throughput_meter
    import swtm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    swtm_in_if.sink                req,
    swtm_out_if.source             rsp
);
    state_t state_reg, state_next;

    // configuration
    logic [GAP_W-1:0] min_gap_reg, min_gap_next;
    logic [GAP_W-1:0] wrap_guess_reg, wrap_guess_next;

    // meter state
    slot_t             oldest_reg, oldest_next;
    count_t            count_reg, count_next;
    logic [BYTES_W-1:0] total_reg, total_next;
    logic              frozen_reg, frozen_next;
    logic [TIME_W-1:0] freeze_reg, freeze_next;

    // current word and working values
    kind_t                     kind_reg, kind_next;
    logic [TIME_W-1:0]         now_reg, now_next;
    logic signed [BYTES_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]         stopped_reg, stopped_next;
    count_t                    idx_reg, idx_next;
    logic [TIME_W-1:0]         span_reg, span_next;
    logic [BYTES_W-1:0]        bytes_reg, bytes_next;
    logic [RATE_W-1:0]         rate_reg, rate_next;

    // output holding register
    logic               out_valid_reg, out_valid_next;
    logic [RATE_W-1:0]  out_rate_reg, out_rate_next;
    logic [BYTES_W-1:0] out_total_reg, out_total_next;
    logic [HELD_W-1:0]  out_held_reg, out_held_next;
    logic               out_susp_reg, out_susp_next;

    // RAM port
    logic    mem_we;
    slot_t   mem_waddr;
    sample_t mem_wdata;
    slot_t   mem_raddr;
    sample_t mem_rdata;

    // divider
    logic              div_start;
    logic [PROD_W-1:0] product;
    logic [RATE_W-1:0] div_quotient;
    logic              div_done;

    logic               accept;
    logic               out_free;
    slot_t              newest_slot;
    slot_t              append_slot;
    slot_t              res_slot;
    slot_t              oldest_inc;
    logic signed [SUM_W-1:0] cnt_ext;
    logic signed [SUM_W-1:0] delta;
    logic signed [SUM_W-1:0] sum;
    logic [BYTES_W-1:0] sat_total;
    logic               take;
    logic [TIME_W-1:0]  meas_time;
    logic [PROD_W-1:0]  bytes_wide;
    logic [COUNT_W-1:0] idx_inc;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign idx_inc  = idx_reg + COUNT_W'(1);

    always_comb
    begin
        if (count_reg == '0)
        begin
            newest_slot = oldest_reg;
        end
        else
        begin
            newest_slot = wrap_slot((SLOT_W + 1)'(oldest_reg) + (SLOT_W + 1)'(count_reg)
                                    - (SLOT_W + 1)'(1));
        end
    end

    assign append_slot = wrap_slot((SLOT_W + 1)'(oldest_reg) + (SLOT_W + 1)'(count_reg));
    assign res_slot    = wrap_slot((SLOT_W + 1)'(oldest_reg) + (SLOT_W + 1)'(idx_reg));
    assign oldest_inc  = wrap_slot((SLOT_W + 1)'(oldest_reg) + (SLOT_W + 1)'(1));

    // signed delta on the total, saturating at zero and full scale
    assign cnt_ext = {{(SUM_W - BYTES_W){cnt_reg[BYTES_W-1]}}, cnt_reg};
    assign delta   = (kind_reg == KIND_ROLLBACK) ? -cnt_ext : cnt_ext;
    assign sum     = $signed({{(SUM_W - BYTES_W){1'b0}}, total_reg}) + delta;

    always_comb
    begin
        if (sum[SUM_W-1])
        begin
            sat_total = '0;
        end
        else if (sum[SUM_W-2:BYTES_W] != '0)
        begin
            sat_total = '1;
        end
        else
        begin
            sat_total = sum[BYTES_W-1:0];
        end
    end

    // record a sample on an empty window, a wrapped clock or a large enough gap
    assign take = (count_reg == '0)
               || (mem_rdata.stamp > now_reg)
               || ((now_reg - mem_rdata.stamp) >= {{(TIME_W - GAP_W){1'b0}}, min_gap_reg});

    assign meas_time = frozen_reg ? freeze_reg : now_reg;

    // bytes * 1000 = bytes * (1024 - 16 - 8)
    assign bytes_wide = PROD_W'(bytes_reg);
    assign product    = (bytes_wide << 10) - (bytes_wide << 4) - (bytes_wide << 3);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_RATE_RD;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        if (!cnt_reg[BYTES_W-1])
                        begin
                            state_next = ST_CHECK;
                        end
                    end
                    KIND_RESUME:
                    begin
                        if (frozen_reg && count_reg != '0)
                        begin
                            state_next = ST_RES_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RATE_RD;
                    end
                endcase
            end
            ST_CHECK:
            begin
                state_next = ST_RATE_RD;
            end
            ST_RES_RD:
            begin
                state_next = ST_RES_WR;
            end
            ST_RES_WR:
            begin
                state_next = (idx_inc == count_reg) ? ST_RATE_RD : ST_RES_RD;
            end
            ST_RATE_RD:
            begin
                state_next = ST_RATE_CALC;
            end
            ST_RATE_CALC:
            begin
                state_next = (count_reg == '0) ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                state_next = (span_reg == '0) ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        min_gap_next    = min_gap_reg;
        wrap_guess_next = wrap_guess_reg;
        oldest_next     = oldest_reg;
        count_next      = count_reg;
        total_next      = total_reg;
        frozen_next     = frozen_reg;
        freeze_next     = freeze_reg;
        kind_next       = kind_reg;
        now_next        = now_reg;
        cnt_next        = cnt_reg;
        stopped_next    = stopped_reg;
        idx_next        = idx_reg;
        span_next       = span_reg;
        bytes_next      = bytes_reg;
        rate_next       = rate_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_rate_next   = out_rate_reg;
        out_total_next  = out_total_reg;
        out_held_next   = out_held_reg;
        out_susp_next   = out_susp_reg;
        mem_we          = 1'b0;
        mem_waddr       = append_slot;
        mem_wdata       = {now_reg, total_reg};
        mem_raddr       = oldest_reg;
        div_start       = 1'b0;
        req.ready       = (state_reg == ST_IDLE);

        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MIN_GAP:    min_gap_next    = cfg_data[GAP_W-1:0];
                REG_WRAP_GUESS: wrap_guess_next = cfg_data[GAP_W-1:0];
                default:        min_gap_next    = min_gap_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = kind_t'(req.kind);
                    now_next  = req.now_ms;
                    cnt_next  = req.byte_count;
                end
            end
            ST_APPLY:
            begin
                // fetch the newest sample for the gap check
                mem_raddr = newest_slot;
                case (kind_reg)
                    KIND_ADD:
                    begin
                        total_next = sat_total;
                        if (cnt_reg[BYTES_W-1])
                        begin
                            count_next  = '0;
                            oldest_next = '0;
                        end
                    end
                    KIND_ROLLBACK:
                    begin
                        total_next  = sat_total;
                        count_next  = '0;
                        oldest_next = '0;
                    end
                    KIND_SUSPEND:
                    begin
                        if (!frozen_reg)
                        begin
                            frozen_next = 1'b1;
                            freeze_next = now_reg;
                        end
                    end
                    KIND_RESUME:
                    begin
                        if (frozen_reg)
                        begin
                            frozen_next  = 1'b0;
                            stopped_next = now_reg - freeze_reg;
                            idx_next     = '0;
                        end
                    end
                    default:
                    begin
                        total_next = total_reg;
                    end
                endcase
            end
            ST_CHECK:
            begin
                if (take)
                begin
                    mem_we = 1'b1;
                    if (count_reg < COUNT_W'(WINDOW))
                    begin
                        mem_waddr  = append_slot;
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        // full ring: overwrite and drop the oldest
                        mem_waddr   = oldest_reg;
                        oldest_next = oldest_inc;
                    end
                end
            end
            ST_RES_RD:
            begin
                mem_raddr = res_slot;
            end
            ST_RES_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = res_slot;
                mem_wdata = {mem_rdata.stamp + stopped_reg, mem_rdata.total};
                idx_next  = idx_inc;
            end
            ST_RATE_RD:
            begin
                mem_raddr = oldest_reg;
            end
            ST_RATE_CALC:
            begin
                if (meas_time < mem_rdata.stamp)
                begin
                    span_next = {{(TIME_W - GAP_W){1'b0}}, wrap_guess_reg};
                end
                else
                begin
                    span_next = meas_time - mem_rdata.stamp;
                end
                bytes_next = (total_reg >= mem_rdata.total) ? total_reg - mem_rdata.total : '0;
                if (count_reg == '0)
                begin
                    rate_next = '0;
                end
            end
            ST_MUL:
            begin
                if (span_reg == '0)
                begin
                    rate_next = '0;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rate_next = div_quotient;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_rate_next  = rate_reg;
                    out_total_next = total_reg;
                    out_held_next  = HELD_W'(count_reg);
                    out_susp_next  = frozen_reg;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            min_gap_reg    <= MIN_GAP_RESET;
            wrap_guess_reg <= WRAP_GUESS_RESET;
            oldest_reg     <= '0;
            count_reg      <= '0;
            total_reg      <= '0;
            frozen_reg     <= 1'b0;
            freeze_reg     <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            min_gap_reg    <= min_gap_next;
            wrap_guess_reg <= wrap_guess_next;
            oldest_reg     <= oldest_next;
            count_reg      <= count_next;
            total_reg      <= total_next;
            frozen_reg     <= frozen_next;
            freeze_reg     <= freeze_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        now_reg       <= now_next;
        cnt_reg       <= cnt_next;
        stopped_reg   <= stopped_next;
        span_reg      <= span_next;
        bytes_reg     <= bytes_next;
        rate_reg      <= rate_next;
        out_rate_reg  <= out_rate_next;
        out_total_reg <= out_total_next;
        out_held_reg  <= out_held_next;
        out_susp_reg  <= out_susp_next;
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.rate         = out_rate_reg;
    assign rsp.total_bytes  = out_total_reg;
    assign rsp.samples_held = out_held_reg;
    assign rsp.is_suspended = out_susp_reg;

    swtm_ram #(
        .DEPTH (WINDOW),
        .WIDTH ($bits(sample_t))
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    swtm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product),
        .divisor  (span_reg),
        .quotient (div_quotient),
        .done     (div_done)
    );
endmodule

FILE: design/swtm_ram.sv
// Generic simple dual-port RAM with registered read data.
module swtm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: design/swtm_div.sv
// Restoring divider, one quotient bit per cycle, low quotient bits returned.
module swtm_div
    import swtm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output logic [RATE_W-1:0] quotient,
    output logic              done
);
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [PROD_W-1:0]    quo_reg, quo_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_W:0]      trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when it fits
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = TIME_W'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient = quo_reg[RATE_W-1:0];
    assign done     = done_reg;
endmodule

FILE: design/swtm_checker.sv
// Port-level checks on the throughput meter, bound to the top level.
module swtm_checker
    import swtm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_ready,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [RATE_W-1:0]  rsp_rate,
    input logic [HELD_W-1:0]  rsp_samples_held
);
    // a waiting report word stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("report word dropped while stalled");

    // one command word in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word taken while busy");

    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_samples_held <= WINDOW)
        else $error("more samples reported than the window holds");

    a_empty_rate: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_samples_held == '0 |-> rsp_rate == '0)
        else $error("nonzero rate with an empty window");
endmodule

bind sliding_window_throughput_meter swtm_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_rate         (rsp.rate),
    .rsp_samples_held (rsp.samples_held)
);
